>>> hdl/assert_macros.svh
// assertion macros included by remote_drive_frame_handler
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdfh assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdfh assertion failed");

`endif

>>> hdl/rdfh_pkg.sv
// types, codes and constants of the remote drive frame handler
// used by every module of the block; depends on nothing
package rdfh_pkg;

    localparam int FRAME_BYTES = 4;
    localparam int HOLD_BYTES  = FRAME_BYTES - 1;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_CONNECT = 2'd2;
    localparam logic [1:0] CMD_DROP    = 2'd3;

    localparam logic [1:0] MOTOR_NONE = 2'd0;
    localparam logic [1:0] MOTOR_STOP = 2'd1;
    localparam logic [1:0] MOTOR_FWD  = 2'd2;
    localparam logic [1:0] MOTOR_BACK = 2'd3;

    localparam logic [1:0] REG_SERVO_MIN = 2'd0;
    localparam logic [1:0] REG_SERVO_MAX = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [7:0]  SERVO_MIN_RST = 8'd0;
    localparam logic [7:0]  SERVO_MAX_RST = 8'd180;
    localparam logic [15:0] TIMEOUT_RST   = 16'd500;

    localparam logic signed [7:0] DEAD_BAND    = 8'sd5;
    localparam logic [7:0]        SERVO_CENTER = 8'd90;
    // x / 10 as (x * 6554) >> 16, exact for x below 16384
    localparam logic [12:0]       RECIP_TEN    = 13'd6554;
    localparam int                RECIP_SHIFT  = 16;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic       control_active;
    } rdfh_in_t;

    typedef struct packed {
        logic       frame_accepted;
        logic       checksum_error;
        logic [1:0] motor_action;
        logic       servo_valid;
        logic [7:0] servo_angle;
        logic       timeout_brake;
    } rdfh_out_t;

    typedef struct packed {
        logic       frame_accepted;
        logic       checksum_error;
        logic       drive;
        logic       timeout_brake;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } rdfh_mid_t;

    typedef struct packed {
        logic [7:0]  servo_min;
        logic [7:0]  servo_max;
        logic [15:0] timeout;
    } rdfh_cfg_t;

endpackage

>>> hdl/rdfh_queue.sv
// small first-in first-out queue of packed words
// used between front and back and at the result side; uses rdfh_pkg
module rdfh_queue
    import rdfh_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0]   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W_Q'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hdl/rdfh_front.sv
// front part: decodes commands, assembles frames, checks checksums, runs the watchdog
// uses rdfh_pkg; feeds the middle queue
module rdfh_front
    import rdfh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  rdfh_in_t  request,
    input  rdfh_cfg_t cfg,
    output rdfh_mid_t entry
);
    logic [7:0]       frame_bytes_reg [HOLD_BYTES];
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             link_up_reg, link_up_next;
    logic             braked_reg, braked_next;
    logic [15:0]      silence_reg, silence_next;
    logic             byte_we;
    logic [7:0]       sum;
    logic [15:0]      silence_inc;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < HOLD_BYTES; i++)
        begin
            sum = sum ^ frame_bytes_reg[i];
        end
    end

    assign silence_inc = (silence_reg == 16'hFFFF) ? silence_reg : silence_reg + 16'd1;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        link_up_next    = link_up_reg;
        braked_next     = braked_reg;
        silence_next    = silence_reg;
        byte_we         = 1'b0;
        entry           = '0;
        entry.byte0     = frame_bytes_reg[0];
        entry.byte1     = frame_bytes_reg[1];
        unique case (request.command)
            CMD_BYTE:
            begin
                if (link_up_reg)
                begin
                    if (byte_count_reg < CNT_W'(HOLD_BYTES))
                    begin
                        byte_we         = 1'b1;
                        byte_count_next = byte_count_reg + 1'b1;
                    end
                    else
                    begin
                        byte_count_next = '0;
                        if (sum == request.rx_byte)
                        begin
                            entry.frame_accepted = 1'b1;
                            entry.drive          = request.control_active;
                            silence_next         = '0;
                            braked_next          = 1'b0;
                        end
                        else
                        begin
                            entry.checksum_error = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                silence_next = silence_inc;
                if (link_up_reg && (silence_inc > cfg.timeout) && !braked_reg
                    && request.control_active)
                begin
                    braked_next         = 1'b1;
                    entry.timeout_brake = 1'b1;
                end
            end
            CMD_CONNECT:
            begin
                link_up_next    = 1'b1;
                byte_count_next = '0;
                silence_next    = '0;
                braked_next     = 1'b0;
            end
            CMD_DROP:
            begin
                link_up_next    = 1'b0;
                byte_count_next = '0;
            end
            default:
            begin
                link_up_next = link_up_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            link_up_reg    <= 1'b0;
            braked_reg     <= 1'b0;
            silence_reg    <= '0;
        end
        else if (take)
        begin
            byte_count_reg <= byte_count_next;
            link_up_reg    <= link_up_next;
            braked_reg     <= braked_next;
            silence_reg    <= silence_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && byte_we)
        begin
            frame_bytes_reg[byte_count_reg] <= request.rx_byte;
        end
    end

endmodule

>>> hdl/rdfh_back.sv
// back part: turns a classified transaction into motor and servo settings
// uses rdfh_pkg; reads the middle queue and writes the result queue
module rdfh_back
    import rdfh_pkg::*;
(
    input  rdfh_mid_t entry,
    input  rdfh_cfg_t cfg,
    output rdfh_out_t result
);
    logic [7:0]         mag;
    logic [10:0]        nine_mag;
    logic [23:0]        prod;
    logic [7:0]         quot;
    logic signed [9:0]  angle;
    logic signed [9:0]  lim_min;
    logic signed [9:0]  lim_max;
    logic [7:0]         clamped;
    logic [1:0]         motor;

    assign mag      = entry.byte1[7] ? (8'd0 - entry.byte1) : entry.byte1;
    assign nine_mag = {mag, 3'b000} + {3'b000, mag};
    assign prod     = nine_mag * RECIP_TEN;
    assign quot     = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign angle    = entry.byte1[7]
                      ? $signed({2'b00, SERVO_CENTER}) - $signed({2'b00, quot})
                      : $signed({2'b00, SERVO_CENTER}) + $signed({2'b00, quot});
    assign lim_min  = $signed({2'b00, cfg.servo_min});
    assign lim_max  = $signed({2'b00, cfg.servo_max});

    always_comb
    begin
        if (angle < lim_min)
        begin
            clamped = cfg.servo_min;
        end
        else if (angle > lim_max)
        begin
            clamped = cfg.servo_max;
        end
        else
        begin
            clamped = angle[7:0];
        end
    end

    always_comb
    begin
        if ($signed(entry.byte0) > DEAD_BAND)
        begin
            motor = MOTOR_FWD;
        end
        else if ($signed(entry.byte0) < -DEAD_BAND)
        begin
            motor = MOTOR_BACK;
        end
        else
        begin
            motor = MOTOR_STOP;
        end
    end

    always_comb
    begin
        result                = '0;
        result.frame_accepted = entry.frame_accepted;
        result.checksum_error = entry.checksum_error;
        result.timeout_brake  = entry.timeout_brake;
        if (entry.drive)
        begin
            result.motor_action = motor;
            result.servo_valid  = 1'b1;
            result.servo_angle  = clamped;
        end
        else
        begin
            result.motor_action = MOTOR_NONE;
        end
    end

endmodule

>>> hdl/remote_drive_frame_handler.sv
// channel   | handshake       | payload
// request   | push / full     | rdfh_in_t  command, rx_byte, control_active
// result    | pop / empty     | rdfh_out_t flags, motor_action, servo_angle
// config    | cfg_write       | cfg_index selects register, cfg_data value
//
// one transaction per cycle while full is low, one result each; the front part
// updates frame and watchdog state in the accepting cycle, the back part
// computes motor and servo when the transaction leaves the middle queue, so a
// result shows on the result ports after the middle queue and the result queue;
// full rises only when both queues fill under a stalled result side;
// asynchronous active-low reset, no clearing pass
module remote_drive_frame_handler
    import rdfh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  rdfh_in_t    request,
    input  logic        pop,
    output logic        empty,
    output rdfh_out_t   result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    `include "assert_macros.svh"

    rdfh_cfg_t cfg_reg;
    rdfh_mid_t front_entry;
    rdfh_mid_t back_entry;
    rdfh_out_t back_result;
    logic      take;
    logic      mid_empty;
    logic      out_full;
    logic      back_move;

    assign take      = push && !full;
    assign back_move = !mid_empty && !out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.servo_min <= SERVO_MIN_RST;
            cfg_reg.servo_max <= SERVO_MAX_RST;
            cfg_reg.timeout   <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SERVO_MIN: cfg_reg.servo_min <= cfg_data[7:0];
                REG_SERVO_MAX: cfg_reg.servo_max <= cfg_data[7:0];
                REG_TIMEOUT:   cfg_reg.timeout   <= cfg_data;
                default:       cfg_reg.timeout   <= cfg_reg.timeout;
            endcase
        end
    end

    rdfh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .request (request),
        .cfg     (cfg_reg),
        .entry   (front_entry)
    );

    rdfh_queue #(
        .WIDTH ($bits(rdfh_mid_t)),
        .DEPTH (DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .wdata (front_entry),
        .full  (full),
        .pop   (back_move),
        .rdata (back_entry),
        .empty (mid_empty)
    );

    rdfh_back u_back (
        .entry  (back_entry),
        .cfg    (cfg_reg),
        .result (back_result)
    );

    rdfh_queue #(
        .WIDTH ($bits(rdfh_out_t)),
        .DEPTH (DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_move),
        .wdata (back_result),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    `ASSERT_IMPL(a_flags_exclusive, !empty, !(result.frame_accepted && result.checksum_error))
    `ASSERT_IMPL(a_servo_needs_frame, !empty && result.servo_valid,
        result.frame_accepted && (result.motor_action != MOTOR_NONE))
    `ASSERT_IMPL(a_brake_alone, !empty && result.timeout_brake,
        !result.frame_accepted && !result.checksum_error && !result.servo_valid)
    `ASSERT_NEXT(a_back_fills_out, back_move, !empty)

endmodule

>>> test/testbench.sv
// testbench of the remote drive frame handler: a directed plan, then random phases
// results come from plan rows or a frame and watchdog model, each checked field by field
// depends on rdfh_pkg and remote_drive_frame_handler
module testbench;
    import rdfh_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int DEAD_ZONE    = 5;
    localparam int CENTER_DEG   = 90;
    localparam int SWING_NUM    = 90;
    localparam int SWING_DEN    = 100;

    localparam rdfh_out_t QUIET   = '0;
    localparam rdfh_out_t BAD_SUM = '{1'b0, 1'b1, MOTOR_NONE, 1'b0, 8'd0, 1'b0};

    typedef struct {
        rdfh_in_t  item;
        bit        typed;
        rdfh_out_t want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    rdfh_in_t    request;
    logic        pop;
    logic        empty;
    rdfh_out_t   result;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor state and its copy of the registers
    logic [7:0]  seen_bytes [HOLD_BYTES];
    int          seen_count;
    bit          link_is_up;
    bit          braked;
    logic [15:0] silence;
    logic [7:0]  angle_floor;
    logic [7:0]  angle_ceiling;
    logic [15:0] brake_after;

    rdfh_out_t   pending_outcomes [$];
    rdfh_out_t   due;
    plan_row_t   plan [$];
    int          fault_count;
    int          cycle_count;
    bit          idle_on;
    bit          hold_start;
    int          hold_left;

    int floors   [PHASES] = '{0, 0, 45, 180, 100, 0, 180, 30};
    int ceilings [PHASES] = '{180, 180, 135, 0, 60, 0, 180, 150};
    int waits    [PHASES] = '{500, 3, 1, 0, 65535, 10, 2, 7};

    remote_drive_frame_handler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic rdfh_in_t make_item(input logic [1:0] cmd, input logic [7:0] data,
                                           input logic ctl);
        rdfh_in_t it;
        it.command        = cmd;
        it.rx_byte        = data;
        it.control_active = ctl;
        return it;
    endfunction

    function automatic rdfh_out_t frame_outcome(input rdfh_in_t it);
        rdfh_out_t r;
        int        lead;
        int        steer;
        int        ang;
        r = '0;
        case (it.command)
            CMD_BYTE:
            begin
                if (link_is_up)
                begin
                    if (seen_count < HOLD_BYTES)
                    begin
                        seen_bytes[seen_count] = it.rx_byte;
                        seen_count++;
                    end
                    else
                    begin
                        seen_count = 0;
                        if ((seen_bytes[0] ^ seen_bytes[1] ^ seen_bytes[2]) == it.rx_byte)
                        begin
                            r.frame_accepted = 1'b1;
                            silence = '0;
                            braked = 1'b0;
                            if (it.control_active)
                            begin
                                lead = $signed(seen_bytes[0]);
                                steer = $signed(seen_bytes[1]);
                                if (lead > DEAD_ZONE)
                                    r.motor_action = MOTOR_FWD;
                                else if (lead < -DEAD_ZONE)
                                    r.motor_action = MOTOR_BACK;
                                else
                                    r.motor_action = MOTOR_STOP;
                                ang = CENTER_DEG + (steer * SWING_NUM) / SWING_DEN;
                                if (ang < int'(angle_floor))
                                    ang = angle_floor;
                                else if (ang > int'(angle_ceiling))
                                    ang = angle_ceiling;
                                r.servo_valid = 1'b1;
                                r.servo_angle = 8'(ang);
                            end
                        end
                        else
                            r.checksum_error = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                if (silence != 16'hFFFF)
                    silence = silence + 16'd1;
                if (link_is_up && silence > brake_after && !braked && it.control_active)
                begin
                    braked = 1'b1;
                    r.timeout_brake = 1'b1;
                end
            end
            CMD_CONNECT:
            begin
                link_is_up = 1'b1;
                seen_count = 0;
                silence = '0;
                braked = 1'b0;
            end
            default:
            begin
                link_is_up = 1'b0;
                seen_count = 0;
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [7:0] data, input logic ctl,
                           input bit typed, input rdfh_out_t want);
        plan_row_t row;
        row.item  = make_item(cmd, data, ctl);
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic send_item(input rdfh_in_t it, input bit typed, input rdfh_out_t want);
        rdfh_out_t predicted;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        request <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted = frame_outcome(it);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SERVO_MIN: angle_floor   = val[7:0];
            REG_SERVO_MAX: angle_ceiling = val[7:0];
            REG_TIMEOUT:   brake_after   = val;
            default:       ;
        endcase
    endtask

    task automatic run_phase(input int n);
        int         sent;
        int         kind;
        int         burst;
        logic [7:0] b [4];
        logic       ctl;
        sent = 0;
        send_item(make_item(CMD_CONNECT, 8'($urandom_range(255)), 1'($urandom_range(1))),
                  1'b0, QUIET);
        sent++;
        while (sent < n)
        begin
            kind = $urandom_range(99);
            ctl = ($urandom_range(9) != 0);
            if (kind < 55)
            begin
                // well-formed frames mostly, some with a corrupted checksum
                b[0] = $urandom_range(1) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(16)) - 8'd8;
                b[1] = 8'($urandom_range(255));
                b[2] = 8'($urandom_range(255));
                b[3] = b[0] ^ b[1] ^ b[2];
                if (kind >= 45)
                    b[3] = b[3] ^ 8'($urandom_range(1, 255));
                for (int k = 0; k < 4; k++)
                    send_item(make_item(CMD_BYTE, b[k], k == 3 ? ctl : 1'($urandom_range(1))),
                              1'b0, QUIET);
                sent += 4;
            end
            else if (kind < 75)
            begin
                burst = $urandom_range(1, 12);
                repeat (burst)
                    send_item(make_item(CMD_TICK, 8'($urandom_range(255)), ctl), 1'b0, QUIET);
                sent += burst;
            end
            else if (kind < 82)
            begin
                send_item(make_item(CMD_BYTE, 8'($urandom_range(255)), ctl), 1'b0, QUIET);
                sent++;
            end
            else if (kind < 88)
            begin
                send_item(make_item(CMD_CONNECT, 8'($urandom_range(255)), ctl), 1'b0, QUIET);
                sent++;
            end
            else if (kind < 93)
            begin
                // link drops, a few bytes and ticks go by, then it comes back
                send_item(make_item(CMD_DROP, 8'($urandom_range(255)), ctl), 1'b0, QUIET);
                burst = $urandom_range(1, 4);
                repeat (burst)
                    send_item(make_item($urandom_range(1) ? CMD_TICK : CMD_BYTE,
                                        8'($urandom_range(255)), 1'($urandom_range(1))),
                              1'b0, QUIET);
                send_item(make_item(CMD_CONNECT, 8'($urandom_range(255)), ctl), 1'b0, QUIET);
                sent += burst + 2;
            end
            else
            begin
                send_item(make_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                                    1'($urandom_range(1))), 1'b0, QUIET);
                sent++;
            end
        end
    endtask

    task automatic report(input string what, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t %s expected %0d actual %0d", $time, what, want_v, got_v);
            fault_count++;
        end
    endtask

    // result side: random pop, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (hold_start)
        begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t transaction expected none actual %h", $time, result);
                fault_count++;
            end
            else
            begin
                due = pending_outcomes.pop_front();
                report("frame_accepted", due.frame_accepted, result.frame_accepted);
                report("checksum_error", due.checksum_error, result.checksum_error);
                report("motor_action", due.motor_action, result.motor_action);
                report("servo_valid", due.servo_valid, result.servo_valid);
                report("servo_angle", due.servo_angle, result.servo_angle);
                report("timeout_brake", due.timeout_brake, result.timeout_brake);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        request = '0;
        pop = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SERVO_MIN;
        cfg_data = '0;
        fault_count = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        hold_start = 1'b0;
        hold_left = 0;
        seen_count = 0;
        link_is_up = 1'b0;
        braked = 1'b0;
        silence = '0;
        angle_floor = SERVO_MIN_RST;
        angle_ceiling = SERVO_MAX_RST;
        brake_after = TIMEOUT_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // link down, then connect
        add_row(CMD_BYTE, 8'h12, 1'b1, 1'b1, QUIET);
        add_row(CMD_TICK, 8'h00, 1'b1, 1'b1, QUIET);
        add_row(CMD_CONNECT, 8'hFF, 1'b0, 1'b1, QUIET);
        // full forward, servo clamped high
        add_row(CMD_BYTE, 8'h7F, 1'b0, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h7F, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h00, 1'b0, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h00, 1'b1, 1'b0, QUIET);
        // full backward, servo clamped low
        add_row(CMD_BYTE, 8'h80, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h80, 1'b0, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'hFF, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'hFF, 1'b1, 1'b0, QUIET);
        // edge of the dead band gives stop
        add_row(CMD_BYTE, 8'hFB, 1'b0, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h64, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h00, 1'b0, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h9F, 1'b1, 1'b0, QUIET);
        // bad checksum
        add_row(CMD_BYTE, 8'hFA, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h01, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h00, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h00, 1'b1, 1'b1, BAD_SUM);
        // good frame outside control mode
        add_row(CMD_BYTE, 8'h06, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h9C, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h00, 1'b1, 1'b1, QUIET);
        add_row(CMD_BYTE, 8'h9A, 1'b0, 1'b0, QUIET);
        // reconnect while up, drop twice
        add_row(CMD_CONNECT, 8'h00, 1'b1, 1'b1, QUIET);
        add_row(CMD_DROP, 8'h55, 1'b1, 1'b1, QUIET);
        add_row(CMD_DROP, 8'hAA, 1'b0, 1'b1, QUIET);

        foreach (plan[i])
            send_item(plan[i].item, plan[i].typed, plan[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_register(REG_SERVO_MIN, 16'(floors[p]));
            write_register(REG_SERVO_MAX, 16'(ceilings[p]));
            write_register(REG_TIMEOUT, 16'(waits[p]));
            idle_on = (p != 3);
            if (p == 1)
                hold_start = 1'b1;
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rdfh_pkg.sv
hdl/rdfh_queue.sv
hdl/rdfh_front.sv
hdl/rdfh_back.sv
hdl/remote_drive_frame_handler.sv
test/testbench.sv
